// ----- sv/bctd_pkg.sv -----
// Package of the block cache tag directory: directory size, command and
// status codes, and the layout of one directory entry in the entry memory.
// No dependencies; used by bctd_ram's instance owner block_cache_tag_directory_lru.
package bctd_pkg;

    // directory size and derived widths
    localparam int ENTRIES = 32;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    // command codes carried on s_tuser
    typedef enum logic [1:0] {
        CMD_GET     = 2'd0,
        CMD_RELEASE = 2'd1,
        CMD_PIN     = 2'd2,
        CMD_UNPIN   = 2'd3
    } cmd_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_DONE   = 2'd0,
        ST_ALLOC  = 2'd1,
        ST_NOFREE = 2'd2,
        ST_ERROR  = 2'd3
    } status_t;

    // one directory entry as stored in the entry memory
    typedef struct packed {
        logic        used;
        logic [7:0]  device;
        logic [31:0] block;
        logic [15:0] refcount;
        logic [31:0] stamp;
        logic        data_valid;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

// ----- sv/bctd_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies; read data holds while the read enable is low.
module bctd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- sv/block_cache_tag_directory_lru.sv -----
// Top level of the block cache tag directory with refcount and LRU reuse.
// Depends on bctd_pkg (types, codes, sizes) and bctd_ram (entry memory).
//
// Usage:
//   The slave channel (s_tvalid/s_tready) takes one command transaction:
//   s_tuser holds the command, s_tdata the device, block number, target
//   entry and current tick. The master channel returns exactly one result
//   transaction per command: entry index, status and the disk-read flag.
//   A get command walks the entry memory one entry a cycle (one read port,
//   registered read data) before its result is loaded. Release, pin and
//   unpin read one entry and write it back. One command is worked on at a
//   time, the next taken in the cycle after the result is loaded; s_tready
//   is high while idle, also while a result waits for the receiver. If the
//   receiver stalls, the next command finishes its scan or read and then
//   holds its write-back and result until the output register is free.
//   Reset (aresetn low, synchronous) clears the control state and the
//   per-entry written flags, so every entry reads as all zero afterwards;
//   no clearing pass runs and commands are taken in the first idle cycle.
module block_cache_tag_directory_lru (
    input  logic        aclk,
    input  logic        aresetn,
    // command: [7:0] device_id, [39:8] block_number, [44:40] entry_index,
    //          [76:45] now_tick, [79:77] zero
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,
    // [1:0] command
    input  logic [1:0]  s_tuser,
    // result: [4:0] result_entry, [6:5] status, [7] needs_read
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata
);

    import bctd_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_READ,
        S_FINISH
    } state_t;

    state_t             state_reg, state_next;
    cmd_t               cmd_reg, cmd_next;
    logic [7:0]         dev_reg, dev_next;
    logic [31:0]        blk_reg, blk_next;
    logic [4:0]         idx_reg, idx_next;
    logic [31:0]        tick_reg, tick_next;

    logic [CNT_W-1:0]   issue_cnt_reg, issue_cnt_next;
    logic               q_live_reg, q_live_next;
    logic [IDX_W-1:0]   q_addr_reg, q_addr_next;
    logic               q_init_reg, q_init_next;

    logic               hit_found_reg, hit_found_next;
    logic [IDX_W-1:0]   hit_idx_reg, hit_idx_next;
    entry_t             hit_rec_reg, hit_rec_next;
    logic               free_found_reg, free_found_next;
    logic [IDX_W-1:0]   free_idx_reg, free_idx_next;
    logic [31:0]        free_stamp_reg, free_stamp_next;

    logic [ENTRIES-1:0] init_reg, init_next;

    logic               m_tvalid_reg, m_tvalid_next;
    logic [4:0]         res_entry_reg, res_entry_next;
    status_t            res_status_reg, res_status_next;
    logic               res_read_reg, res_read_next;

    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    entry_t             wr_rec;
    logic [ENTRY_W-1:0] ram_q;
    entry_t             eff_q;

    logic               s_accept;
    logic               out_free;
    logic               match;
    logic               better_free;
    logic               out_of_range;
    logic [IDX_W-1:0]   tgt_idx;

    // entry memory
    bctd_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_entry_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_rec),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (ram_q)
    );

    // an entry never written since reset reads as all zero
    assign eff_q = q_init_reg ? entry_t'(ram_q) : '0;

    assign s_accept     = s_tvalid && (state_reg == S_IDLE);
    assign out_free     = !m_tvalid_reg || m_tready;
    assign match        = eff_q.used && (eff_q.device == dev_reg) && (eff_q.block == blk_reg);
    assign better_free  = (eff_q.refcount == 16'd0) &&
                          (!free_found_reg || (eff_q.stamp < free_stamp_reg));
    assign out_of_range = 32'(idx_reg) >= 32'(ENTRIES);
    assign tgt_idx      = IDX_W'(idx_reg);

    // next-state, memory access and result logic
    always_comb begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        dev_next        = dev_reg;
        blk_next        = blk_reg;
        idx_next        = idx_reg;
        tick_next       = tick_reg;
        issue_cnt_next  = issue_cnt_reg;
        hit_found_next  = hit_found_reg;
        hit_idx_next    = hit_idx_reg;
        hit_rec_next    = hit_rec_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        free_stamp_next = free_stamp_reg;
        init_next       = init_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        res_entry_next  = res_entry_reg;
        res_status_next = res_status_reg;
        res_read_next   = res_read_reg;
        rd_en           = 1'b0;
        rd_addr         = issue_cnt_reg[IDX_W-1:0];
        wr_en           = 1'b0;
        wr_addr         = tgt_idx;
        wr_rec          = eff_q;

        unique case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    cmd_next        = cmd_t'(s_tuser);
                    dev_next        = s_tdata[7:0];
                    blk_next        = s_tdata[39:8];
                    idx_next        = s_tdata[44:40];
                    tick_next       = s_tdata[76:45];
                    issue_cnt_next  = '0;
                    hit_found_next  = 1'b0;
                    free_found_next = 1'b0;
                    state_next      = (cmd_t'(s_tuser) == CMD_GET) ? S_SCAN : S_READ;
                end
            end

            S_SCAN: begin
                // issue one read a cycle
                if (issue_cnt_reg != CNT_W'(ENTRIES)) begin
                    rd_en          = 1'b1;
                    issue_cnt_next = issue_cnt_reg + 1'b1;
                end
                // examine the entry read in the previous cycle
                if (q_live_reg) begin
                    if (match && !hit_found_reg) begin
                        hit_found_next = 1'b1;
                        hit_idx_next   = q_addr_reg;
                        hit_rec_next   = eff_q;
                    end
                    if (better_free) begin
                        free_found_next = 1'b1;
                        free_idx_next   = q_addr_reg;
                        free_stamp_next = eff_q.stamp;
                    end
                    if (q_addr_reg == IDX_W'(ENTRIES - 1)) begin
                        state_next = S_FINISH;
                    end
                end
            end

            S_READ: begin
                rd_en      = 1'b1;
                rd_addr    = tgt_idx;
                state_next = S_FINISH;
            end

            S_FINISH: begin
                // write back and load the result once the output register is free
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                    res_read_next = 1'b0;
                    if (cmd_reg == CMD_GET) begin
                        priority if (hit_found_reg) begin
                            res_entry_next = 5'(hit_idx_reg);
                            wr_addr        = hit_idx_reg;
                            wr_rec         = hit_rec_reg;
                            if (hit_rec_reg.refcount == COUNT_MAX) begin
                                res_status_next = ST_ERROR;
                            end else begin
                                res_status_next   = ST_DONE;
                                res_read_next     = !hit_rec_reg.data_valid;
                                wr_en             = 1'b1;
                                wr_rec.refcount   = hit_rec_reg.refcount + 16'd1;
                                wr_rec.data_valid = 1'b1;
                            end
                        end else if (free_found_reg) begin
                            res_entry_next    = 5'(free_idx_reg);
                            res_status_next   = ST_ALLOC;
                            res_read_next     = 1'b1;
                            wr_en             = 1'b1;
                            wr_addr           = free_idx_reg;
                            wr_rec.used       = 1'b1;
                            wr_rec.device     = dev_reg;
                            wr_rec.block      = blk_reg;
                            wr_rec.refcount   = 16'd1;
                            wr_rec.stamp      = free_stamp_reg;
                            wr_rec.data_valid = 1'b1;
                        end else begin
                            res_entry_next  = 5'd0;
                            res_status_next = ST_NOFREE;
                        end
                    end else begin
                        res_entry_next  = idx_reg;
                        res_status_next = ST_DONE;
                        priority if (out_of_range) begin
                            res_status_next = ST_ERROR;
                        end else if (cmd_reg == CMD_PIN) begin
                            if (eff_q.refcount == COUNT_MAX) begin
                                res_status_next = ST_ERROR;
                            end else begin
                                wr_en           = 1'b1;
                                wr_rec.refcount = eff_q.refcount + 16'd1;
                            end
                        end else if (eff_q.refcount == 16'd0) begin
                            res_status_next = ST_ERROR;
                        end else begin
                            wr_en           = 1'b1;
                            wr_rec.refcount = eff_q.refcount - 16'd1;
                            if (cmd_reg == CMD_RELEASE) begin
                                wr_rec.stamp = tick_reg;
                            end
                        end
                    end
                    if (wr_en) begin
                        init_next[wr_addr] = 1'b1;
                    end
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // track which address the read data belongs to
    assign q_live_next = rd_en;
    assign q_addr_next = rd_en ? rd_addr : q_addr_reg;
    assign q_init_next = rd_en ? init_reg[rd_addr] : q_init_reg;

    // hold state, control and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            q_live_reg     <= 1'b0;
            init_reg       <= '0;
            m_tvalid_reg   <= 1'b0;
            issue_cnt_reg  <= '0;
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            q_live_reg     <= q_live_next;
            init_reg       <= init_next;
            m_tvalid_reg   <= m_tvalid_next;
            issue_cnt_reg  <= issue_cnt_next;
            hit_found_reg  <= hit_found_next;
            free_found_reg <= free_found_next;
        end
        cmd_reg        <= cmd_next;
        dev_reg        <= dev_next;
        blk_reg        <= blk_next;
        idx_reg        <= idx_next;
        tick_reg       <= tick_next;
        q_addr_reg     <= q_addr_next;
        q_init_reg     <= q_init_next;
        hit_idx_reg    <= hit_idx_next;
        hit_rec_reg    <= hit_rec_next;
        free_idx_reg   <= free_idx_next;
        free_stamp_reg <= free_stamp_next;
        res_entry_reg  <= res_entry_next;
        res_status_reg <= res_status_next;
        res_read_reg   <= res_read_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {res_read_reg, res_status_reg, res_entry_reg};

endmodule

// ----- tb/sv/tb_block_cache_tag_directory_lru.sv -----
// Testbench of block_cache_tag_directory_lru: drives get, release, pin and unpin
// commands and checks every result against a directory predictor held here.
// Depends on bctd_pkg (codes, sizes) and the block_cache_tag_directory_lru RTL.
module tb_block_cache_tag_directory_lru;
    import bctd_pkg::*;

    localparam int PRESSURE_HOLD = 300;
    localparam int STALL_LIMIT   = 4000;
    localparam int DRAIN_CYCLES  = 40;

    typedef struct packed {
        logic [4:0] entry;
        status_t    status;
        logic       needs_read;
    } dir_result_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    // [7:0] device_id, [39:8] block_number, [44:40] entry_index, [76:45] now_tick, [79:77] zero
    logic [79:0] s_tdata;
    // [1:0] command
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // [4:0] result_entry, [6:5] status, [7] needs_read
    logic [7:0]  m_tdata;

    // predicted directory contents
    logic        dir_used   [ENTRIES];
    logic [7:0]  dir_device [ENTRIES];
    logic [31:0] dir_block  [ENTRIES];
    logic [15:0] dir_count  [ENTRIES];
    logic [31:0] dir_stamp  [ENTRIES];
    logic        dir_valid  [ENTRIES];

    dir_result_t pending_results[$];
    dir_result_t want;

    logic [31:0] block_pool  [40];
    logic [7:0]  device_pool [4];
    logic [31:0] fresh_block = 32'h0001_0000;

    int send_idle_pct;
    int recv_idle_pct;
    bit hold_req;
    int hold_left;
    int fail_count;
    int commands_sent;
    int results_checked;
    int status_seen [4];

    block_cache_tag_directory_lru u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Apply one accepted command to the predicted directory and queue its result
    function automatic void apply_to_directory(cmd_t c, logic [7:0] dev, logic [31:0] blk,
                                               logic [4:0] idx, logic [31:0] tick);
        dir_result_t r;
        int          hit;
        int          pick;
        r.entry      = idx;
        r.status     = ST_DONE;
        r.needs_read = 1'b0;
        hit          = -1;
        pick         = -1;
        if (c == CMD_GET) begin
            for (int i = 0; i < ENTRIES; i++)
                if (hit < 0 && dir_used[i] && dir_device[i] == dev && dir_block[i] == blk)
                    hit = i;
            if (hit >= 0) begin
                r.entry = 5'(hit);
                if (dir_count[hit] == COUNT_MAX) begin
                    r.status = ST_ERROR;
                end else begin
                    dir_count[hit]++;
                    r.needs_read   = !dir_valid[hit];
                    dir_valid[hit] = 1'b1;
                end
            end else begin
                // oldest release stamp among free entries, lowest index on a tie
                for (int i = 0; i < ENTRIES; i++)
                    if (dir_count[i] == 0 && (pick < 0 || dir_stamp[i] < dir_stamp[pick]))
                        pick = i;
                if (pick < 0) begin
                    r.entry  = '0;
                    r.status = ST_NOFREE;
                end else begin
                    dir_used[pick]   = 1'b1;
                    dir_device[pick] = dev;
                    dir_block[pick]  = blk;
                    dir_count[pick]  = 16'd1;
                    dir_valid[pick]  = 1'b1;
                    r.entry          = 5'(pick);
                    r.status         = ST_ALLOC;
                    r.needs_read     = 1'b1;
                end
            end
        end else if (int'(idx) >= ENTRIES) begin
            r.status = ST_ERROR;
        end else if (c == CMD_PIN) begin
            if (dir_count[idx] == COUNT_MAX)
                r.status = ST_ERROR;
            else
                dir_count[idx]++;
        end else if (dir_count[idx] == 0) begin
            r.status = ST_ERROR;
        end else begin
            dir_count[idx]--;
            if (c == CMD_RELEASE)
                dir_stamp[idx] = tick;
        end
        status_seen[r.status]++;
        pending_results.push_back(r);
    endfunction

    // Random entry with a nonzero count, or -1 when none is held
    function automatic int pick_held_entry();
        int held[$];
        for (int i = 0; i < ENTRIES; i++)
            if (dir_count[i] != 0)
                held.push_back(i);
        return (held.size() != 0) ? held[$urandom_range(held.size() - 1)] : -1;
    endfunction

    // Offer one command from a falling edge; return at the falling edge after acceptance
    task automatic send_cmd(cmd_t c, logic [7:0] dev, logic [31:0] blk,
                            logic [4:0] idx, logic [31:0] tick);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, tick, idx, blk, dev};
        s_tuser  <= c;
        do @(posedge aclk); while (!s_tready);
        apply_to_directory(c, dev, blk, idx, tick);
        commands_sent++;
        @(negedge aclk);
    endtask

    // Hold the sender off until every queued result has been checked
    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    // Allocation order from reset, all-zero tag, partial tag matches, count errors
    task automatic test_directed();
        send_cmd(CMD_GET,     8'h00, 32'h0000_0000, 5'd7,  32'h0);
        send_cmd(CMD_GET,     8'h00, 32'h0000_0000, 5'd0,  32'h0);
        send_cmd(CMD_GET,     8'hFF, 32'hFFFF_FFFF, 5'd31, 32'hFFFF_FFFF);
        send_cmd(CMD_GET,     8'h00, 32'hFFFF_FFFF, 5'd0,  32'h0);
        send_cmd(CMD_GET,     8'hFF, 32'h0000_0000, 5'd0,  32'h0);
        send_cmd(CMD_RELEASE, 8'h00, 32'h0,         5'd0,  32'hFFFF_FFFF);
        send_cmd(CMD_RELEASE, 8'hFF, 32'hFFFF_FFFF, 5'd0,  32'h0);
        send_cmd(CMD_RELEASE, 8'h00, 32'h0,         5'd0,  32'h1234_5678);
        send_cmd(CMD_UNPIN,   8'h00, 32'h0,         5'd31, 32'h0);
        send_cmd(CMD_PIN,     8'h00, 32'h0,         5'd31, 32'h0);
        send_cmd(CMD_GET,     8'h01, 32'h0000_0001, 5'd0,  32'h0);
        send_cmd(CMD_GET,     8'h00, 32'h0000_0000, 5'd0,  32'h0);
        send_cmd(CMD_UNPIN,   8'h00, 32'h0,         5'd31, 32'h0);
        send_cmd(CMD_RELEASE, 8'h00, 32'h0,         5'd1,  32'hFFFF_FFFF);
        send_cmd(CMD_RELEASE, 8'h00, 32'h0,         5'd2,  32'h0000_0001);
        send_cmd(CMD_PIN,     8'h00, 32'h0,         5'd3,  32'h0);
        send_cmd(CMD_UNPIN,   8'h00, 32'h0,         5'd3,  32'h0);
        send_cmd(CMD_RELEASE, 8'h00, 32'h0,         5'd31, 32'h0);
        send_cmd(CMD_GET,     8'hFF, 32'hFFFF_FFFF, 5'd0,  32'h0);
        wait_results_drained();
    endtask

    // Fill the directory, miss with nothing free, then free all with maximal stamps
    task automatic test_no_free_and_lru();
        int free_left;
        free_left = 0;
        for (int i = 0; i < ENTRIES; i++)
            if (dir_count[i] == 0)
                free_left++;
        // each fresh miss takes exactly one free entry
        repeat (free_left) begin
            send_cmd(CMD_GET, 8'h5A, fresh_block, 5'($urandom), $urandom);
            fresh_block++;
        end
        send_cmd(CMD_GET, 8'hA5, fresh_block, 5'd0, 32'h0);
        fresh_block++;
        // drop every count to zero, stamping the top tick everywhere
        for (int i = 0; i < ENTRIES; i++)
            while (dir_count[i] != 0)
                send_cmd(CMD_RELEASE, 8'h00, 32'h0, 5'(i), 32'hFFFF_FFFF);
        send_cmd(CMD_GET, 8'h5A, fresh_block, 5'd0, 32'h0);
        send_cmd(CMD_RELEASE, 8'h00, 32'h0, 5'd0, 32'h0000_0010);
        send_cmd(CMD_GET, 8'h5A, fresh_block + 32'd1, 5'd0, 32'h0);
        send_cmd(CMD_RELEASE, 8'h00, 32'h0, 5'd0, 32'h0000_0020);
        // a released entry still holds its tag and hits
        send_cmd(CMD_GET, 8'h5A, fresh_block + 32'd1, 5'd0, 32'h0);
        fresh_block += 32'd2;
        wait_results_drained();
    endtask

    // Stall the receiver for a long stretch while commands keep coming
    task automatic test_receiver_hold_off();
        hold_req = 1'b1;
        for (int i = 0; i < 8; i++)
            send_cmd(cmd_t'(i % 2 == 0 ? CMD_GET : CMD_PIN), device_pool[i % 4],
                     block_pool[i], 5'($urandom), $urandom);
        wait_results_drained();
    endtask

    // Mixed traffic over a small tag pool so that hits, evictions and reuse all occur
    task automatic test_random_traffic(int count);
        int          roll;
        int          target;
        logic [7:0]  dev;
        logic [31:0] blk;
        for (int n = 0; n < count; n++) begin
            roll   = $urandom_range(99);
            dev    = ($urandom_range(9) == 0) ? 8'($urandom) : device_pool[$urandom_range(3)];
            blk    = ($urandom_range(9) == 0) ? $urandom : block_pool[$urandom_range(39)];
            target = pick_held_entry();
            if (target < 0 || $urandom_range(99) < 15)
                target = $urandom_range(ENTRIES - 1);
            if (roll < 45)
                send_cmd(CMD_GET, dev, blk, 5'($urandom), $urandom);
            else if (roll < 75)
                send_cmd(CMD_RELEASE, dev, blk, 5'(target), $urandom);
            else if (roll < 85)
                send_cmd(CMD_PIN, dev, blk, 5'($urandom), $urandom);
            else
                send_cmd(CMD_UNPIN, dev, blk, 5'(target), $urandom);
        end
        wait_results_drained();
    endtask

    // Drive the result ready, with a long hold-off on request
    always @(negedge aclk) begin
        if (hold_req) begin
            hold_left = PRESSURE_HOLD;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Compare each result transaction with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("result with no command pending: m_tdata=%h", m_tdata);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (m_tdata[4:0] !== want.entry) begin
                    $error("result_entry: expected %0d, got %0d", want.entry, m_tdata[4:0]);
                    fail_count++;
                end
                if (m_tdata[6:5] !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_tdata[6:5]);
                    fail_count++;
                end
                if (m_tdata[7] !== want.needs_read) begin
                    $error("needs_read: expected %0d, got %0d", want.needs_read, m_tdata[7]);
                    fail_count++;
                end
            end
        end
    end

    // End the run when no transaction moves for too long
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("block_cache_tag_directory_lru verification failed");
        $finish;
    end

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = CMD_GET;
        for (int i = 0; i < ENTRIES; i++) begin
            dir_used[i]   = 1'b0;
            dir_device[i] = '0;
            dir_block[i]  = '0;
            dir_count[i]  = '0;
            dir_stamp[i]  = '0;
            dir_valid[i]  = 1'b0;
        end
        block_pool[0] = 32'h0000_0000;
        block_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < 40; i++)
            block_pool[i] = $urandom;
        device_pool[0] = 8'h00;
        device_pool[1] = 8'hFF;
        device_pool[2] = 8'($urandom);
        device_pool[3] = 8'($urandom);
        send_idle_pct = 21;
        recv_idle_pct = 74;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_directed();
        test_no_free_and_lru();
        test_receiver_hold_off();
        test_random_traffic(150);

        send_idle_pct = 74;
        recv_idle_pct = 21;
        test_random_traffic(150);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(150);

        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Sent %0d commands, checked %0d results under three stall profiles",
                 commands_sent, results_checked);
        $display("Status mix: %0d done, %0d allocated, %0d no free entry, %0d count errors",
                 status_seen[ST_DONE], status_seen[ST_ALLOC], status_seen[ST_NOFREE],
                 status_seen[ST_ERROR]);
        if (fail_count == 0) begin
            $display("block_cache_tag_directory_lru verification clean");
        end else begin
            $display("block_cache_tag_directory_lru verification failed");
        end
        $finish;
    end

endmodule
